FILE: rtl/core/mfap_pkg.sv
// Shared constants and types for the max-flow augmenting path block.
package mfap_pkg;

    localparam int NODES_DEF    = 64;
    localparam int CAP_BITS_DEF = 16;
    localparam int FLOW_BITS    = 22;
    localparam logic [FLOW_BITS-1:0] FLOW_MAX = 22'h3FFFFF;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SINK_NODE   = 2'd2;

    localparam logic [6:0] NODE_COUNT_RST  = 7'd2;
    localparam logic [5:0] SOURCE_NODE_RST = 6'd0;
    localparam logic [5:0] SINK_NODE_RST   = 6'd1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_SAME_NODE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_LOAD,
        ST_SINIT,
        ST_SSEED,
        ST_POP,
        ST_POPW,
        ST_SCAN,
        ST_A_PAR,
        ST_A_MAT,
        ST_A_MIN,
        ST_B_PAR,
        ST_B_MAT,
        ST_B_WR1,
        ST_B_WR2,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/core/mfap_ram.sv
// Generic simple dual-port RAM with registered read.
module mfap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/max_flow_augmenting_paths.sv
// Edmonds-Karp max flow over a residual matrix held in block RAM.
// Edge loading: one edge per cycle up to the last edge, a read-modify-write of the matrix in two stages.
// Flow: per search, the visited marks of all n nodes are cleared, then each dequeued node has its row scanned;
//   per augmenting path, two parent walks find the bottleneck and then update the residuals.
// Result: emitted once after the last edge, then the matrix is swept clean.
// Reset: synchronous, active low; a sweep of the whole matrix, NODES rounded up to a power of two
//   and squared (4096 entries by default), runs before the first edge is taken.
module max_flow_augmenting_paths
    import mfap_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int CAP_BITS = CAP_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,   // from_node[5:0], to_node[11:6], edge_capacity[27:12]
    input  logic                     s_tlast,   // last_edge
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // total_flow[21:0]
    output logic [0:0]               m_tuser    // status[0]
);

    localparam int NW   = $clog2(NODES);
    localparam int AW   = 2 * NW;
    localparam int NCW  = $clog2(NODES + 1);
    localparam int CMPW = (NCW > 7) ? NCW : 7;
    localparam int RW   = CAP_BITS + 1;
    localparam int SW   = ((RW > FLOW_BITS) ? RW : FLOW_BITS) + 1;
    localparam logic [CMPW-1:0] NODES_C = CMPW'(NODES);

    function automatic logic [NW-1:0] to_idx(input logic [5:0] x);
        logic [CMPW-1:0] t;
        t = CMPW'(x);
        return t[NW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [6:0] node_count_reg;
    logic [5:0] source_reg, sink_reg;

    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                stg_valid_reg, stg_valid_next;
    logic                stg_last_reg, stg_last_next;
    logic                stg_ok_reg, stg_ok_next;
    logic [AW-1:0]       stg_addr_reg, stg_addr_next;
    logic [CAP_BITS-1:0] stg_cap_reg, stg_cap_next;
    logic                fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]       fwd_addr_reg, fwd_addr_next;
    logic [NCW-1:0]      v_reg, v_next;
    logic                pend_reg, pend_next;
    logic [NW-1:0]       pend_v_reg, pend_v_next;
    logic [NCW-1:0]      head_reg, head_next;
    logic [NCW-1:0]      tail_reg, tail_next;
    logic [NW-1:0]       u_reg, u_next;
    logic [NW-1:0]       p_reg, p_next;
    logic [RW-1:0]       inc_reg, inc_next;
    logic                first_reg, first_next;
    logic                found_reg, found_next;
    logic                status_reg, status_next;
    logic [FLOW_BITS-1:0] sum_reg, sum_next;
    logic                m_valid_reg, m_valid_next;
    logic [FLOW_BITS-1:0] m_total_reg, m_total_next;
    logic                m_status_reg, m_status_next;

    // memory ports
    logic          mat_we;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [RW:0]   mat_wdata, mat_rdata;
    logic          vis_we, vis_wdata, vis_rdata;
    logic [NW-1:0] vis_waddr, vis_raddr;
    logic          par_we;
    logic [NW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic          que_we;
    logic [NW-1:0] que_waddr, que_wdata, que_raddr, que_rdata;

    logic [CMPW-1:0] n_eff;
    logic [NCW-1:0]  nn;
    logic [NW-1:0]   src_idx, snk_idx, in_from, in_to;
    logic            in_ok, accept, eff_loaded, src_ok;
    logic [CAP_BITS-1:0] in_cap;
    logic [31:0]     cap32;
    logic [RW-1:0]   r_val;
    logic [SW-1:0]   sum_wide;

    mfap_ram #(.WIDTH(RW + 1), .DEPTH(1 << AW)) u_mat (
        .aclk(aclk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
        .raddr(mat_raddr), .rdata(mat_rdata)
    );
    mfap_ram #(.WIDTH(1), .DEPTH(NODES)) u_vis (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );
    mfap_ram #(.WIDTH(NW), .DEPTH(NODES)) u_par (
        .aclk(aclk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );
    mfap_ram #(.WIDTH(NW), .DEPTH(NODES)) u_que (
        .aclk(aclk), .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
        .raddr(que_raddr), .rdata(que_rdata)
    );

    assign n_eff   = (CMPW'(node_count_reg) > NODES_C) ? NODES_C : CMPW'(node_count_reg);
    assign nn      = n_eff[NCW-1:0];
    assign src_idx = to_idx(source_reg);
    assign snk_idx = to_idx(sink_reg);
    assign src_ok  = (CMPW'(source_reg) < n_eff) && (CMPW'(sink_reg) < n_eff);
    assign in_from = to_idx(s_tdata[5:0]);
    assign in_to   = to_idx(s_tdata[11:6]);
    assign in_ok   = (CMPW'(s_tdata[5:0]) < n_eff) && (CMPW'(s_tdata[11:6]) < n_eff);
    assign cap32   = 32'(s_tdata[27:12]);
    assign in_cap  = cap32[CAP_BITS-1:0];
    assign r_val   = mat_rdata[RW-1:0];

    assign s_tready = (state_reg == ST_LOAD) && !(stg_valid_reg && stg_last_reg);
    assign accept   = s_tvalid && s_tready;
    // an entry written by the previous edge is not yet visible in the read data
    assign eff_loaded = mat_rdata[RW] || (fwd_valid_reg && fwd_addr_reg == stg_addr_reg);
    assign sum_wide   = SW'(sum_reg) + SW'(inc_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_total_reg};
    assign m_tuser  = m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
            source_reg     <= SOURCE_NODE_RST;
            sink_reg       <= SINK_NODE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NODE_COUNT:  node_count_reg <= cfg_wdata;
                REG_SOURCE_NODE: source_reg     <= cfg_wdata[5:0];
                REG_SINK_NODE:   sink_reg       <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            sweep_reg     <= '0;
            stg_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            sum_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            stg_valid_reg <= stg_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        stg_last_reg <= stg_last_next;
        stg_ok_reg   <= stg_ok_next;
        stg_addr_reg <= stg_addr_next;
        stg_cap_reg  <= stg_cap_next;
        fwd_addr_reg <= fwd_addr_next;
        v_reg        <= v_next;
        pend_v_reg   <= pend_v_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        u_reg        <= u_next;
        p_reg        <= p_next;
        inc_reg      <= inc_next;
        first_reg    <= first_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        m_total_reg  <= m_total_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        stg_valid_next = accept;
        stg_last_next  = s_tlast;
        stg_ok_next    = in_ok;
        stg_addr_next  = {in_from, in_to};
        stg_cap_next   = in_cap;
        fwd_valid_next = 1'b0;
        fwd_addr_next  = stg_addr_reg;
        v_next         = v_reg;
        pend_next      = 1'b0;
        pend_v_next    = v_reg[NW-1:0];
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        p_next         = p_reg;
        inc_next       = inc_reg;
        first_next     = first_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        sum_next       = sum_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_total_next   = m_total_reg;
        m_status_next  = m_status_reg;

        mat_we    = 1'b0;
        mat_waddr = stg_addr_reg;
        mat_wdata = {1'b1, RW'(stg_cap_reg)};
        mat_raddr = {in_from, in_to};
        vis_we    = 1'b0;
        vis_waddr = v_reg[NW-1:0];
        vis_wdata = 1'b0;
        vis_raddr = v_reg[NW-1:0];
        par_we    = 1'b0;
        par_waddr = pend_v_reg;
        par_wdata = u_reg;
        par_raddr = u_reg;
        que_we    = 1'b0;
        que_waddr = tail_reg[NW-1:0];
        que_wdata = pend_v_reg;
        que_raddr = head_reg[NW-1:0];

        unique case (state_reg)
            ST_CLR: begin
                mat_we     = 1'b1;
                mat_waddr  = sweep_reg;
                mat_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (stg_valid_reg && stg_ok_reg && !eff_loaded) begin
                    mat_we         = 1'b1;
                    fwd_valid_next = 1'b1;
                end
                if (stg_valid_reg && stg_last_reg) begin
                    v_next = '0;
                    if (source_reg == sink_reg) begin
                        status_next = STATUS_SAME_NODE;
                        state_next  = ST_EMIT;
                    end else begin
                        status_next = STATUS_OK;
                        state_next  = src_ok ? ST_SINIT : ST_EMIT;
                    end
                end
            end
            ST_SINIT: begin
                vis_we = 1'b1;
                v_next = v_reg + 1'b1;
                if (v_reg == nn - 1'b1) begin
                    state_next = ST_SSEED;
                end
            end
            ST_SSEED: begin
                vis_we     = 1'b1;
                vis_waddr  = src_idx;
                vis_wdata  = 1'b1;
                que_we     = 1'b1;
                que_waddr  = '0;
                que_wdata  = src_idx;
                head_next  = '0;
                tail_next  = NCW'(1);
                found_next = 1'b0;
                state_next = ST_POP;
            end
            ST_POP: begin
                if (head_reg < tail_reg) begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_POPW;
                end else if (found_reg) begin
                    u_next     = snk_idx;
                    first_next = 1'b1;
                    state_next = ST_A_PAR;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_POPW: begin
                u_next     = que_rdata;
                v_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                mat_raddr = {u_reg, v_reg[NW-1:0]};
                if (v_reg < nn) begin
                    v_next    = v_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_POP;
                end
                // claim an unvisited neighbor with residual left
                if (pend_reg && !vis_rdata && r_val != '0) begin
                    vis_we    = 1'b1;
                    vis_waddr = pend_v_reg;
                    vis_wdata = 1'b1;
                    par_we    = 1'b1;
                    que_we    = 1'b1;
                    tail_next = tail_reg + 1'b1;
                    if (pend_v_reg == snk_idx) begin
                        found_next = 1'b1;
                    end
                end
            end
            ST_A_PAR: begin
                state_next = ST_A_MAT;
            end
            ST_A_MAT: begin
                p_next     = par_rdata;
                mat_raddr  = {par_rdata, u_reg};
                state_next = ST_A_MIN;
            end
            ST_A_MIN: begin
                if (first_reg || r_val < inc_reg) begin
                    inc_next = r_val;
                end
                first_next = 1'b0;
                if (p_reg == src_idx) begin
                    u_next     = snk_idx;
                    state_next = ST_B_PAR;
                end else begin
                    u_next     = p_reg;
                    state_next = ST_A_PAR;
                end
            end
            ST_B_PAR: begin
                state_next = ST_B_MAT;
            end
            ST_B_MAT: begin
                p_next     = par_rdata;
                mat_raddr  = {par_rdata, u_reg};
                state_next = ST_B_WR1;
            end
            ST_B_WR1: begin
                mat_we     = 1'b1;
                mat_waddr  = {p_reg, u_reg};
                mat_wdata  = {mat_rdata[RW], r_val - inc_reg};
                mat_raddr  = {u_reg, p_reg};
                state_next = ST_B_WR2;
            end
            ST_B_WR2: begin
                mat_we     = 1'b1;
                mat_waddr  = {u_reg, p_reg};
                mat_wdata  = {mat_rdata[RW], r_val + inc_reg};
                u_next     = p_reg;
                state_next = (p_reg == src_idx) ? ST_ADD : ST_B_PAR;
            end
            ST_ADD: begin
                sum_next   = (sum_wide > SW'(FLOW_MAX)) ? FLOW_MAX : sum_wide[FLOW_BITS-1:0];
                v_next     = '0;
                state_next = ST_SINIT;
            end
            ST_EMIT: begin
                // hold until the output slot is free
                if (!m_valid_reg) begin
                    m_valid_next  = 1'b1;
                    m_total_next  = status_reg ? '0 : sum_reg;
                    m_status_next = status_reg;
                    sum_next      = '0;
                    sweep_next    = '0;
                    state_next    = ST_CLR;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    a_same_node_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("same-node status with nonzero flow");

    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("edge taken after last edge");

    a_scan_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && vis_we && v_reg < nn |-> vis_waddr != vis_raddr)
        else $error("visited mark read and written at one entry");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> tail_reg <= nn && head_reg <= tail_reg)
        else $error("search queue pointers out of range");

    a_emit_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && !m_valid_reg |=> state_reg == ST_CLR && m_valid_reg)
        else $error("result not issued on leaving emit");

endmodule
